// File: hdl/mwg_pkg.sv
package mwg_pkg;

    localparam int ACTIVE_WORDS = 624;
    localparam int MID_OFFSET   = 397;
    localparam int ADDR_W       = 10;
    localparam int WL_W         = 11;

    // twist sequencer index covers a read-ahead, then one write per table word
    localparam int TWIST_LAST   = ACTIVE_WORDS + 1;

    localparam logic [31:0] LCG_MULT           = 32'd69069;
    localparam logic [31:0] TWIST_MASK         = 32'h9908_B0DF;
    localparam logic [31:0] TEMPER_B           = 32'h9D2C_5680;
    localparam logic [31:0] TEMPER_C           = 32'hEFC6_0000;
    localparam logic [31:0] HIGH_BIT           = 32'h8000_0000;
    localparam logic [31:0] LOW_BITS           = 32'h7FFF_FFFF;
    localparam logic [31:0] DEFAULT_SEED_RESET = 32'd4357;

    localparam logic MODE_DRAW = 1'b0;
    localparam logic MODE_SEED = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [31:0] seed;
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FILL,
        S_TWIST,
        S_READ
    } eng_state_t;

    function automatic logic [31:0] temper(input logic [31:0] y_in);
        logic [31:0] y;
        begin
            y = y_in;
            y = y ^ (y >> 11);
            y = y ^ ((y << 7) & TEMPER_B);
            y = y ^ ((y << 15) & TEMPER_C);
            temper = y ^ (y >> 18);
        end
    endfunction

endpackage

// File: hdl/mwg_fifo.sv
module mwg_fifo #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr_reg + 1'b1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr_reg + 1'b1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: hdl/mwg_engine.sv
module mwg_engine
    import mwg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] default_seed,
    input  cmd_t        cmd,
    input  logic        cmd_empty,
    output logic        cmd_pop,
    input  logic        res_full,
    output logic        res_push,
    output logic [31:0] res_word
);

    logic [31:0] table_mem [ACTIVE_WORDS];

    eng_state_t              state_reg, state_next;
    logic signed [WL_W-1:0]  words_left_reg, words_left_next;
    logic [ADDR_W-1:0]       rp_reg, rp_next;
    logic [ADDR_W-1:0]       idx_reg, idx_next;
    logic                    twist_after_reg, twist_after_next;
    logic [31:0]             x_reg, x_next;
    logic [31:0]             t0_reg, t0_next;
    logic [31:0]             cur_reg;
    logic [31:0]             rd_a_reg, rd_b_reg;

    logic signed [WL_W-1:0]  wl_dec;
    logic [ADDR_W-1:0]       rp_eff;
    logic [ADDR_W-1:0]       twist_a, twist_b;
    logic [ADDR_W:0]         b_sum;
    logic [31:0]             y_mix, twist_word;
    logic                    take, fill_last, twist_last;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr, addr_a, addr_b;
    logic [31:0]             wr_data;

    always_comb
    begin
        wl_dec     = words_left_reg - 11'sd1;
        rp_eff     = (rp_reg >= ADDR_W'(ACTIVE_WORDS)) ? '0 : rp_reg;
        take       = !cmd_empty && ((cmd.mode == MODE_SEED) || !res_full);
        fill_last  = (idx_reg == ADDR_W'(ACTIVE_WORDS - 1));
        twist_last = (idx_reg == ADDR_W'(TWIST_LAST));
        // read-ahead addresses: next word at idx, far word one step behind
        twist_a    = (idx_reg >= ADDR_W'(ACTIVE_WORDS)) ?
                     ADDR_W'(idx_reg - ADDR_W'(ACTIVE_WORDS)) : idx_reg;
        b_sum      = (ADDR_W + 1)'(idx_reg) + (ADDR_W + 1)'(MID_OFFSET - 1);
        twist_b    = (b_sum >= (ADDR_W + 1)'(ACTIVE_WORDS)) ?
                     ADDR_W'(b_sum - (ADDR_W + 1)'(ACTIVE_WORDS)) : ADDR_W'(b_sum);
        y_mix      = (cur_reg & HIGH_BIT) | (rd_a_reg & LOW_BITS);
        twist_word = rd_b_reg ^ (y_mix >> 1) ^ (y_mix[0] ? TWIST_MASK : 32'h0);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    if (cmd.mode == MODE_SEED)
                    begin
                        state_next = S_FILL;
                    end
                    else if (wl_dec < 0)
                    begin
                        state_next = (wl_dec < -11'sd1) ? S_FILL : S_TWIST;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_FILL:
            begin
                if (fill_last)
                begin
                    state_next = twist_after_reg ? S_TWIST : S_IDLE;
                end
            end
            S_TWIST:
            begin
                if (twist_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        words_left_next  = words_left_reg;
        rp_next          = rp_reg;
        idx_next         = idx_reg;
        twist_after_next = twist_after_reg;
        x_next           = x_reg;
        t0_next          = t0_reg;
        cmd_pop          = 1'b0;
        res_push         = 1'b0;
        res_word         = temper(rd_a_reg);
        wr_en            = 1'b0;
        wr_addr          = idx_reg;
        wr_data          = x_reg;
        addr_a           = rp_eff;
        addr_b           = twist_b;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    cmd_pop  = 1'b1;
                    idx_next = '0;
                    if (cmd.mode == MODE_SEED)
                    begin
                        x_next           = cmd.seed | 32'h1;
                        words_left_next  = '0;
                        twist_after_next = 1'b0;
                    end
                    else if (wl_dec < 0)
                    begin
                        words_left_next  = WL_W'(ACTIVE_WORDS - 1);
                        rp_next          = ADDR_W'(1);
                        x_next           = default_seed | 32'h1;
                        twist_after_next = 1'b1;
                    end
                    else
                    begin
                        words_left_next = wl_dec;
                        rp_next         = ADDR_W'(rp_eff + 1'b1);
                    end
                end
            end
            S_FILL:
            begin
                wr_en    = 1'b1;
                x_next   = 32'(x_reg * LCG_MULT);
                idx_next = fill_last ? '0 : ADDR_W'(idx_reg + 1'b1);
            end
            S_TWIST:
            begin
                addr_a   = twist_a;
                idx_next = ADDR_W'(idx_reg + 1'b1);
                if (idx_reg >= ADDR_W'(2))
                begin
                    wr_en   = 1'b1;
                    wr_addr = ADDR_W'(idx_reg - ADDR_W'(2));
                    wr_data = twist_word;
                end
                if (idx_reg == ADDR_W'(2))
                begin
                    t0_next = twist_word;
                end
                if (twist_last)
                begin
                    res_push = 1'b1;
                    res_word = temper(t0_reg);
                end
            end
            S_READ:
            begin
                res_push = 1'b1;
            end
            default:
            begin
                res_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            words_left_reg  <= -11'sd1;
            rp_reg          <= '0;
            idx_reg         <= '0;
            twist_after_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            words_left_reg  <= words_left_next;
            rp_reg          <= rp_next;
            idx_reg         <= idx_next;
            twist_after_reg <= twist_after_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        t0_reg  <= t0_next;
        cur_reg <= rd_a_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= table_mem[addr_a];
        rd_b_reg <= table_mem[addr_b];
    end

    a_words_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        (words_left_reg >= -11'sd2) && (words_left_reg <= 11'sd623))
        else $error("words left out of range");

    a_rp_range: assert property (@(posedge clk) disable iff (!rst_n)
        rp_reg <= ADDR_W'(ACTIVE_WORDS))
        else $error("read pointer out of range");

    a_twist_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TWIST) && wr_en |-> (wr_addr != addr_a) && (wr_addr != addr_b))
        else $error("twist write collides with read-ahead");

    a_draw_to_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop && (cmd.mode == MODE_DRAW) && (wl_dec >= 0) |=> state_reg == S_READ)
        else $error("plain draw did not go to table read");

endmodule

// File: hdl/mt19937_word_generator_unit.sv
// mt19937 word generator (reload-style twister, 624 active words)
// input queue: drive mode/new_seed and raise push; the item is taken on an
// edge with push high and full low. mode 0 draws one word, mode 1 reseeds
// (seed forced odd) and gives no result.
// result queue: random_word is valid while empty is low and leaves on an
// edge with pop high. a stalled receiver only fills the result queue; the
// engine waits for room before starting a draw, commands keep queueing.
// config: default_seed is written on cfg_valid && cfg_ready (always ready);
// the user must write it only while the block is idle, the block does not
// enforce this. it seeds the table on a draw before any reseed. reset value 4357.
// timing: the engine takes one item at a time from the command queue.
// ordinary draw: take with table read, then temper and push; empty falls
// after the command queue, the engine and the result queue have each
// registered the item when the block is idle. a reseed is taken, then fills
// all 624 table words at one word per cycle. the draw after the table runs
// out (or after a reseed) is taken, then reads ahead and regenerates in
// place at one word per cycle; the first draw after reset also seeds first.
// reset empties both queues and marks the table as never seeded; the
// table itself is not cleared.
module mt19937_word_generator_unit
    import mwg_pkg::*;
#(
    parameter int CMD_DEPTH = 4,
    parameter int RES_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        mode,
    input  logic [31:0] new_seed,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] random_word,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] default_seed
);

    logic [31:0] default_seed_reg;
    cmd_t        cmd_in, cmd_out;
    logic        cmd_empty, cmd_pop;
    logic        res_full, res_push;
    logic [31:0] res_word;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_seed_reg <= DEFAULT_SEED_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            default_seed_reg <= default_seed;
        end
    end

    assign cmd_in.mode = mode;
    assign cmd_in.seed = new_seed;

    mwg_fifo #(
        .DEPTH (CMD_DEPTH),
        .WIDTH ($bits(cmd_t))
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cmd_in),
        .full    (full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_out),
        .empty   (cmd_empty)
    );

    mwg_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .default_seed (default_seed_reg),
        .cmd          (cmd_out),
        .cmd_empty    (cmd_empty),
        .cmd_pop      (cmd_pop),
        .res_full     (res_full),
        .res_push     (res_push),
        .res_word     (res_word)
    );

    mwg_fifo #(
        .DEPTH (RES_DEPTH),
        .WIDTH (32)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_word),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (random_word),
        .empty   (empty)
    );

    a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full queue");

    a_cmd_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command taken from empty queue");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        push && !full |=> !cmd_empty)
        else $error("accepted transaction missing from command queue");

endmodule

// File: sim/mt_word_checker.sv
module mt_word_checker
    import mwg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic        mode,
    input  logic [31:0] new_seed,
    input  logic        empty,
    input  logic        pop,
    input  logic [31:0] random_word,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] default_seed,
    output int          fail_count,
    output int          words_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] state_words [ACTIVE_WORDS];
    int          words_left;
    int          next_index;
    logic [31:0] seed_setting;
    logic [31:0] expected_words [$];
    logic [31:0] want;
    int          errors;

    function automatic logic [31:0] scramble(input logic [31:0] v);
        logic [31:0] y;
        y = v ^ (v >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        return y ^ (y >> 18);
    endfunction

    function void lcg_fill(input logic [31:0] s);
        logic [31:0] x;
        x = s | 32'd1;
        words_left = 0;
        for (int k = 0; k < ACTIVE_WORDS; k++)
        begin
            state_words[k] = x;
            x = x * LCG_MULT;
        end
    endfunction

    // regenerates the whole table in place, later entries see earlier updates
    function logic [31:0] twist_all();
        logic [31:0] y;
        int          nxt;
        int          far;
        if (words_left < -1)
            lcg_fill(seed_setting);
        words_left = ACTIVE_WORDS - 1;
        next_index = 1;
        for (int i = 0; i < ACTIVE_WORDS; i++)
        begin
            nxt = (i + 1) % ACTIVE_WORDS;
            far = (i + MID_OFFSET) % ACTIVE_WORDS;
            y = (state_words[i] & HIGH_BIT) | (state_words[nxt] & LOW_BITS);
            state_words[i] = state_words[far] ^ (y >> 1) ^ (y[0] ? TWIST_MASK : 32'd0);
        end
        return scramble(state_words[0]);
    endfunction

    function logic [31:0] draw_word();
        logic [31:0] w;
        words_left--;
        if (words_left < 0)
            return twist_all();
        if (next_index >= ACTIVE_WORDS)
            next_index = 0;
        w = scramble(state_words[next_index]);
        next_index++;
        return w;
    endfunction

    task report_mismatch(input string what);
        errors++;
        if (errors <= 100)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_left = -1;
            next_index = 0;
            seed_setting = DEFAULT_SEED_RESET;
            expected_words.delete();
            errors = 0;
            fail_count <= 0;
            words_owed <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                seed_setting = default_seed;
            if (pop && !empty)
            begin
                if (expected_words.size() == 0)
                    report_mismatch($sformatf("word %h with nothing outstanding", random_word));
                else
                begin
                    want = expected_words.pop_front();
                    if (random_word !== want)
                        report_mismatch($sformatf("random_word %h, predicted %h",
                                                  random_word, want));
                end
            end
            if (push && !full)
            begin
                if (mode == MODE_DRAW)
                    expected_words.push_back(draw_word());
                else
                    lcg_fill(new_seed);
            end
            fail_count <= errors;
            words_owed <= expected_words.size();
        end
    end

endmodule

// File: sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mwg_pkg::*;

    localparam int HOLD_CYCLES   = 400;
    // room for a queue of reseeds plus a seeding regeneration
    localparam int SETTLE_CYCLES = 3300;
    localparam int STALL_LIMIT   = 20000;
    localparam int RANDOM_ITEMS  = 1100;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        push         = 1'b0;
    logic        mode         = MODE_DRAW;
    logic [31:0] new_seed     = 32'd0;
    logic        pop          = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic [31:0] default_seed = 32'd0;
    wire         full;
    wire         empty;
    wire         cfg_ready;
    wire  [31:0] random_word;

    int fail_count;
    int words_owed;
    int tx_level = 0;
    int rx_level = 0;
    bit rx_hold  = 1'b0;
    int stalled  = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    mt19937_word_generator_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .new_seed     (new_seed),
        .empty        (empty),
        .pop          (pop),
        .random_word  (random_word),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .default_seed (default_seed)
    );

    mt_word_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .new_seed     (new_seed),
        .empty        (empty),
        .pop          (pop),
        .random_word  (random_word),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .default_seed (default_seed),
        .fail_count   (fail_count),
        .words_owed   (words_owed)
    );

    function automatic int pick_gap(input int level);
        int r;
        r = $urandom_range(0, 99);
        if (level == 0)
            return 0;
        if (r < ((level == 1) ? 80 : 50))
            return 0;
        if (r < ((level == 1) ? 97 : 90))
            return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_seed();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0000_0001;
            3: return 32'h8000_0000;
            4: return $urandom() & 32'hFFFF_FFFE;
            default: return $urandom();
        endcase
    endfunction

    // push stays high on return so that a zero gap keeps the stream back to back
    task send_item(input logic m, input logic [31:0] s);
        int gap;
        gap = pick_gap(tx_level);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        mode <= m;
        new_seed <= s;
        do @(posedge clk); while (full);
    endtask

    task drain();
        push <= 1'b0;
        @(posedge clk);
        while (words_owed != 0)
            @(posedge clk);
    endtask

    task settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_seed(input logic [31:0] v);
        cfg_valid <= 1'b1;
        default_seed <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // result side
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold = 1'b0;
            end
            gap = pick_gap(rx_level);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            stalled <= 0;
        else
            stalled <= stalled + 1;
        if (stalled >= STALL_LIMIT)
        begin
            $display("mt19937_word_generator_unit verification failed");
            $finish;
        end
    end

    initial
    begin
        int rand_items;
        int blk;
        int run;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // only the value standing at the first draw ever reaches the table
        write_seed(32'hFFFF_FFFF);
        case ($urandom_range(0, 3))
            0: write_seed(32'h0000_0000);
            1: write_seed(DEFAULT_SEED_RESET);
            2: write_seed($urandom());
            default: ;
        endcase

        // first draw seeds from the register, then regenerates
        send_item(MODE_DRAW, 32'h0000_0000);
        send_item(MODE_DRAW, 32'hFFFF_FFFF);
        send_item(MODE_DRAW, $urandom());
        // zero seed forced odd, draw straight after a reseed
        send_item(MODE_SEED, 32'h0000_0000);
        send_item(MODE_DRAW, 32'h0000_0000);
        send_item(MODE_DRAW, 32'h0000_0000);
        send_item(MODE_SEED, 32'hFFFF_FFFF);
        send_item(MODE_DRAW, 32'hFFFF_FFFF);
        // back-to-back reseeds, even seed then high bit only
        send_item(MODE_SEED, 32'h1234_5678);
        send_item(MODE_SEED, 32'h8000_0000);
        send_item(MODE_DRAW, $urandom());
        send_item(MODE_DRAW, $urandom());

        // receiver stalls long enough for both queues to fill up
        rx_hold = 1'b1;
        repeat (12) send_item(MODE_DRAW, $urandom());
        drain();

        settle();
        write_seed(32'h0000_0000);

        rand_items = 0;
        blk = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            tx_level = $urandom_range(0, 2);
            rx_level = $urandom_range(0, 2);
            if (blk == 0 || $urandom_range(0, 4) == 0)
            begin
                send_item(MODE_SEED, pick_seed());
                rand_items++;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                send_item(MODE_SEED, pick_seed());
                rand_items++;
            end
            // first run is long enough to use up the table and reload it
            if (blk == 0)
                run = 660;
            else if ($urandom_range(0, 9) == 0)
                run = $urandom_range(300, 650);
            else
                run = $urandom_range(1, 40);
            if (run > RANDOM_ITEMS - rand_items)
                run = (RANDOM_ITEMS - rand_items > 1) ? RANDOM_ITEMS - rand_items : 1;
            repeat (run) send_item(MODE_DRAW, $urandom());
            rand_items += run;
            if (blk == 6)
            begin
                settle();
                write_seed(pick_seed());
            end
            blk++;
        end

        settle();
        if (fail_count == 0 && words_owed == 0)
            $display("mt19937_word_generator_unit verification clean");
        else
            $display("mt19937_word_generator_unit verification failed");
        $finish;
    end

endmodule
